FILE: sv/ordered_list_with_value_removal_defines.svh
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Concurrent assertion forms used by the ordered list datapath.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_WITH_VALUE_REMOVAL_DEFINES_SVH
`define ORDERED_LIST_WITH_VALUE_REMOVAL_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define OLVR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define OLVR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/olvr_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Transfer types, code sets and controller/datapath command structures.
// ----------------------------------------------------------------------------
package olvr_pkg;

	// Default number of list entries.
	localparam int DEFAULT_LIST_DEPTH = 16;

	// Request action codes.
	typedef enum logic [2:0] {
		ACT_APPEND     = 3'd0,
		ACT_REM_TAIL   = 3'd1,
		ACT_REM_HEAD   = 3'd2,
		ACT_REM_MATCH  = 3'd3,
		ACT_LIST       = 3'd4
	} action_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	// Request transfer.
	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
	} req_t;

	// Result transfer.
	typedef struct packed {
		logic signed [31:0] item_value;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	// Walk pointer update; the memory read address follows the new pointer.
	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_LAST,
		PTR_INC
	} ptr_op_t;

	// Entry count update.
	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	// Source of the result value.
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_REQ,
		RES_RDATA
	} res_sel_t;

	// Memory write address and data source.
	typedef enum logic {
		WR_TAIL,
		WR_PREV
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_req;
		ptr_op_t  ptr_op;
		logic     mem_rd;
		logic     mem_wr;
		wr_sel_t  wr_sel;
		cnt_op_t  cnt_op;
		logic     emit;
		res_sel_t res_sel;
		status_t  res_status;
		logic     res_last;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] action;
		logic       empty;
		logic       full;
		logic       ptr_last;
		logic       match;
	} ctrl_sts_t;

endpackage

FILE: sv/ordered_list_with_value_removal.sv
// ----------------------------------------------------------------------------
// Ordered list with value removal
// Bounded ordered list of signed 32-bit values with append, remove and list.
// ----------------------------------------------------------------------------
// A request transfer is taken at a rising edge with start high and busy low;
// request.action selects append, remove tail, remove head, remove the first
// entry equal to request.value, or list all. Busy rises the cycle after the
// transfer and falls when the request is finished.
// Each result is shown on result for exactly one cycle with strobe high; the
// receiver cannot stall, so nothing waits on it. Append, a full append and any
// removal or listing on an empty list give one result, registered from the
// decode state. Remove tail gives the last entry. Remove by value walks the
// list one entry per cycle through the single read port of the entry memory
// and remove head takes the head entry; both then shift the later entries
// toward the head at one entry per cycle. A value that is not found is
// searched over the whole list and gives a not-found result. Listing gives
// one result per cycle. Unused action codes give no result. Reset empties
// the list at once; the entries are only read below the entry count, so the
// memory needs no clearing.
// ----------------------------------------------------------------------------
module ordered_list_with_value_removal #(
	parameter int LIST_DEPTH = olvr_pkg::DEFAULT_LIST_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  olvr_pkg::req_t  request,
	output logic            strobe,
	output olvr_pkg::rsp_t  result
);
	import olvr_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// Sequencer.
	olvr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Storage and result path.
	olvr_datapath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

FILE: sv/olvr_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences append, removal, search, shift and listing over the datapath.
// ----------------------------------------------------------------------------
module olvr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  olvr_pkg::ctrl_sts_t   sts,
	output olvr_pkg::ctrl_cmd_t   cmd
);
	import olvr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TAKE,
		ST_FIND,
		ST_SHIFT,
		ST_LIST
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	assign busy = busy_q;

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.wr_sel     = WR_TAIL;
		cmd.cnt_op     = CNT_HOLD;
		cmd.res_sel    = RES_ZERO;
		cmd.res_status = STAT_OK;
		cmd.res_last   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DECODE;
				end
			end

			ST_DECODE: begin
				state_d = ST_IDLE;
				unique case (sts.action)
					ACT_APPEND: begin
						cmd.emit = 1'b1;
						if (sts.full) begin
							cmd.res_status = STAT_FULL;
						end else begin
							cmd.mem_wr  = 1'b1;
							cmd.wr_sel  = WR_TAIL;
							cmd.cnt_op  = CNT_INC;
							cmd.res_sel = RES_REQ;
						end
					end
					ACT_REM_TAIL, ACT_REM_HEAD, ACT_REM_MATCH, ACT_LIST: begin
						if (sts.empty) begin
							cmd.emit       = 1'b1;
							cmd.res_status = STAT_EMPTY;
						end else begin
							cmd.mem_rd = 1'b1;
							cmd.ptr_op = (sts.action == ACT_REM_TAIL) ? PTR_LAST : PTR_ZERO;
							if (sts.action == ACT_REM_MATCH) begin
								state_d = ST_FIND;
							end else if (sts.action == ACT_LIST) begin
								state_d = ST_LIST;
							end else begin
								state_d = ST_TAKE;
							end
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end

			// Read data holds the entry to remove.
			ST_TAKE: begin
				cmd.emit    = 1'b1;
				cmd.res_sel = RES_RDATA;
				if (sts.ptr_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = ST_IDLE;
				end else begin
					cmd.ptr_op = PTR_INC;
					cmd.mem_rd = 1'b1;
					state_d    = ST_SHIFT;
				end
			end

			// Compare one entry per cycle against the request value.
			ST_FIND: begin
				if (sts.match) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_RDATA;
					if (sts.ptr_last) begin
						cmd.cnt_op = CNT_DEC;
						state_d    = ST_IDLE;
					end else begin
						cmd.ptr_op = PTR_INC;
						cmd.mem_rd = 1'b1;
						state_d    = ST_SHIFT;
					end
				end else if (sts.ptr_last) begin
					cmd.emit       = 1'b1;
					cmd.res_status = STAT_NOTFOUND;
					state_d        = ST_IDLE;
				end else begin
					cmd.ptr_op = PTR_INC;
					cmd.mem_rd = 1'b1;
				end
			end

			// Move each later entry one place toward the head.
			ST_SHIFT: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = WR_PREV;
				if (sts.ptr_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = ST_IDLE;
				end else begin
					cmd.ptr_op = PTR_INC;
					cmd.mem_rd = 1'b1;
				end
			end

			// Emit one entry per cycle from head to tail.
			ST_LIST: begin
				cmd.emit     = 1'b1;
				cmd.res_sel  = RES_RDATA;
				cmd.res_last = sts.ptr_last;
				if (sts.ptr_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.ptr_op = PTR_INC;
					cmd.mem_rd = 1'b1;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and registered busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

endmodule

FILE: sv/olvr_datapath.sv
// ----------------------------------------------------------------------------
// Ordered list datapath
// Entry memory, entry count, walk pointer, compare and result register.
// ----------------------------------------------------------------------------
`include "ordered_list_with_value_removal_defines.svh"

module olvr_datapath #(
	parameter int LIST_DEPTH = olvr_pkg::DEFAULT_LIST_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  olvr_pkg::req_t        request,
	input  olvr_pkg::ctrl_cmd_t   cmd,
	output olvr_pkg::ctrl_sts_t   sts,
	output logic                  strobe,
	output olvr_pkg::rsp_t        result
);
	import olvr_pkg::*;

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic signed [31:0] mem_q [LIST_DEPTH];
	logic signed [31:0] rdata_q;
	logic signed [31:0] value_q;
	logic [2:0]         action_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      ptr_d;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               strobe_q;
	rsp_t               result_q;
	logic signed [31:0] res_value;

	// Status back to the controller.
	assign sts.action   = action_q;
	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CW'(LIST_DEPTH));
	assign sts.ptr_last = ((CW'(ptr_q) + CW'(1)) == count_q);
	assign sts.match    = (rdata_q == value_q);

	// Next walk pointer; it is also the memory read address.
	always_comb begin
		case (cmd.ptr_op)
			PTR_ZERO: ptr_d = '0;
			PTR_LAST: ptr_d = AW'(count_q - CW'(1));
			PTR_INC:  ptr_d = ptr_q + AW'(1);
			default:  ptr_d = ptr_q;
		endcase
	end

	// Write port: append at the tail, or shift into the previous slot.
	always_comb begin
		case (cmd.wr_sel)
			WR_PREV: begin
				wr_addr = ptr_q - AW'(1);
				wr_data = rdata_q;
			end
			default: begin
				wr_addr = AW'(count_q);
				wr_data = value_q;
			end
		endcase
	end

	// Result value selection.
	always_comb begin
		case (cmd.res_sel)
			RES_REQ:   res_value = value_q;
			RES_RDATA: res_value = rdata_q;
			default:   res_value = '0;
		endcase
	end

	// Entry memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem_q[ptr_d];
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q <= request.action;
			value_q  <= request.value;
		end
		if (cmd.emit) begin
			result_q.item_value <= res_value;
			result_q.status     <= cmd.res_status;
			result_q.last       <= cmd.res_last;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ptr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			ptr_q    <= ptr_d;
			strobe_q <= cmd.emit;
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// Checks on count bookkeeping and memory reads.
	`OLVR_ASSERT(a_count_bound, count_q <= CW'(LIST_DEPTH), "entry count above list depth")
	`OLVR_ASSERT_IMPL(a_inc_not_full, cmd.cnt_op == CNT_INC, !sts.full, "append to a full list")
	`OLVR_ASSERT_IMPL(a_dec_not_empty, cmd.cnt_op == CNT_DEC, !sts.empty, "removal from empty list")
	`OLVR_ASSERT_IMPL(a_read_valid, cmd.mem_rd, CW'(ptr_d) < count_q, "read beyond the tail")

endmodule

FILE: sim/tb_ordered_list_with_value_removal.sv
// ----------------------------------------------------------------------------
// Ordered list with value removal testbench
// Drives append, remove and list requests through the start/busy command
// port and checks every strobed result against a cycle-free list predictor.
// A directed opening covers empty-list requests, value extremes, duplicates,
// misses and ignored action codes. Random phases then grow, drain and mix
// the list so that it fills and empties many times.
// ----------------------------------------------------------------------------
module tb_ordered_list_with_value_removal;
	timeunit 1ns;
	timeprecision 1ps;

	import olvr_pkg::*;

	localparam int LIST_DEPTH   = DEFAULT_LIST_DEPTH;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 200;
	localparam int QUIET_TAIL   = 30;
	localparam int DRAIN_CYCLES = LIST_DEPTH + 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic strobe;
	rsp_t result;

	ordered_list_with_value_removal #(
		.LIST_DEPTH(LIST_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result)
	);

	// Predicted list contents and the results still due from the block.
	logic signed [31:0] list_entries [LIST_DEPTH];
	int list_count = 0;
	rsp_t due_results [$];
	req_t queued_requests [$];
	logic signed [31:0] recent_appends [$];

	int errors = 0;
	int results_checked = 0;
	int action_counts [5] = '{default: 0};
	int ignored_codes = 0;
	int full_hits = 0;
	int empty_hits = 0;
	int missing_hits = 0;
	int idle_left = 0;
	int transfers = 0;
	rsp_t want;

	// Clock and reset.
	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic rsp_t make_result(logic signed [31:0] v, status_t st, logic lst);
		rsp_t r;
		r.item_value = v;
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	// Take the entry at pos out of the list, closing the gap toward the head.
	function automatic logic signed [31:0] pull_entry(int pos);
		logic signed [31:0] v;
		v = list_entries[pos];
		for (int i = pos; i + 1 < list_count; i++)
			list_entries[i] = list_entries[i + 1];
		list_count--;
		return v;
	endfunction

	// Update the predicted list for one accepted request and queue its results.
	task automatic apply_request(input req_t r);
		int pos;
		pos = -1;
		if (r.action <= ACT_LIST)
			action_counts[r.action]++;
		if (list_count == 0 && r.action != ACT_APPEND && r.action <= ACT_LIST) begin
			due_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
			empty_hits++;
			return;
		end
		case (r.action)
		ACT_APPEND: begin
			if (list_count >= LIST_DEPTH) begin
				due_results.push_back(make_result('0, STAT_FULL, 1'b1));
				full_hits++;
			end else begin
				list_entries[list_count] = r.value;
				list_count++;
				due_results.push_back(make_result(r.value, STAT_OK, 1'b1));
			end
		end
		ACT_REM_TAIL: begin
			due_results.push_back(make_result(pull_entry(list_count - 1), STAT_OK, 1'b1));
		end
		ACT_REM_HEAD: begin
			due_results.push_back(make_result(pull_entry(0), STAT_OK, 1'b1));
		end
		ACT_REM_MATCH: begin
			// Only the match nearest the head goes.
			for (int i = 0; i < list_count && pos < 0; i++)
				if (list_entries[i] == r.value)
					pos = i;
			if (pos >= 0) begin
				due_results.push_back(make_result(pull_entry(pos), STAT_OK, 1'b1));
			end else begin
				due_results.push_back(make_result('0, STAT_NOTFOUND, 1'b1));
				missing_hits++;
			end
		end
		ACT_LIST: begin
			for (int i = 0; i < list_count; i++)
				due_results.push_back(make_result(list_entries[i], STAT_OK,
					i + 1 == list_count));
		end
		default: begin
			ignored_codes++;
		end
		endcase
	endtask

	// Request driver: holds each request until its transfer, then moves on.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else if (!(start && busy)) begin
			if (start) begin
				apply_request(request);
				void'(queued_requests.pop_front());
				transfers++;
				// Idle bursts come and go in stretches and stop near the end.
				if (queued_requests.size() > QUIET_TAIL && (transfers / 40) % 2 == 0
						&& $urandom_range(3) == 0)
					idle_left = $urandom_range(1, 15);
			end
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (queued_requests.size() > 0) begin
				start <= 1'b1;
				request <= queued_requests[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor: every strobe must match the oldest result still due.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, value %0d status %0d last %0d",
					$time, result.item_value, result.status, result.last);
				errors++;
			end else begin
				want = due_results.pop_front();
				results_checked++;
				if (result.item_value !== want.item_value) begin
					$display("%0t: item_value expected %0d, got %0d",
						$time, want.item_value, result.item_value);
					errors++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, result.status);
					errors++;
				end
				if (result.last !== want.last) begin
					$display("%0t: last expected %0b, got %0b",
						$time, want.last, result.last);
					errors++;
				end
			end
		end
	end

	task automatic add_request(input logic [2:0] act, input logic signed [31:0] v);
		req_t r;
		r.action = act;
		r.value = v;
		queued_requests.push_back(r);
		if (act == ACT_APPEND) begin
			recent_appends.push_back(v);
			if (recent_appends.size() > LIST_DEPTH)
				void'(recent_appends.pop_front());
		end
	endtask

	// Values lean toward a small pool and recent appends so that removals hit.
	function automatic logic signed [31:0] pick_value(logic [2:0] act);
		logic signed [31:0] pool [6];
		pool = '{32'sd0, -32'sd1, 32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd42};
		if (act == ACT_REM_MATCH && recent_appends.size() > 0 && $urandom_range(9) < 6)
			return recent_appends[$urandom_range(recent_appends.size() - 1)];
		if ($urandom_range(9) < 4)
			return pool[$urandom_range(5)];
		return $urandom;
	endfunction

	// Growth phases mostly append, drain phases mostly remove, mixed is even.
	function automatic logic [2:0] pick_action(int phase);
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return 3'($urandom_range(5, 7));
		case (phase)
		0: begin
			if (roll < 85)
				return ACT_APPEND;
			if (roll < 90)
				return ACT_LIST;
		end
		1: begin
			if (roll < 20)
				return ACT_APPEND;
			if (roll < 30)
				return ACT_LIST;
		end
		default: begin
			return 3'($urandom_range(0, 4));
		end
		endcase
		return 3'($urandom_range(ACT_REM_TAIL, ACT_REM_MATCH));
	endfunction

	// Stimulus, end of run and verdict.
	initial begin
		int counted;
		int phase;
		logic [2:0] act;

		// Empty list answers and ignored codes.
		add_request(ACT_LIST, 32'sd0);
		add_request(ACT_REM_TAIL, 32'sd0);
		add_request(ACT_REM_HEAD, 32'sd0);
		add_request(ACT_REM_MATCH, 32'sd7);
		add_request(3'd5, 32'sd1);
		add_request(3'd6, -32'sd1);
		add_request(3'd7, 32'sh55555555);
		// A miss on a one-entry list, then extremes and a duplicate.
		add_request(ACT_APPEND, 32'sh7fffffff);
		add_request(ACT_REM_MATCH, 32'sd12345);
		add_request(ACT_APPEND, 32'sh80000000);
		add_request(ACT_APPEND, 32'sd0);
		add_request(ACT_APPEND, -32'sd1);
		add_request(ACT_APPEND, 32'sd0);
		add_request(ACT_LIST, 32'sd0);
		// Duplicate removal takes the one nearest the head; the tail is searched.
		add_request(ACT_REM_MATCH, 32'sd0);
		add_request(ACT_REM_MATCH, 32'sd0);
		add_request(ACT_LIST, 32'sd0);
		add_request(ACT_REM_MATCH, -32'sd1);
		add_request(ACT_REM_TAIL, 32'sd0);
		add_request(ACT_REM_HEAD, 32'sd0);
		add_request(ACT_REM_HEAD, 32'sd0);
		add_request(ACT_LIST, 32'sd0);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			phase = $urandom_range(2);
			repeat ($urandom_range(15, 35)) begin
				if (counted < RANDOM_ITEMS) begin
					act = pick_action(phase);
					add_request(act, pick_value(act));
					if (act <= ACT_LIST)
						counted++;
				end
			end
		end

		wait (arst_n);
		while (queued_requests.size() > 0 || start)
			@(posedge clk);
		while (due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d appends, %0d tail, %0d head and %0d by-value removals, %0d lists;",
			action_counts[ACT_APPEND], action_counts[ACT_REM_TAIL],
			action_counts[ACT_REM_HEAD], action_counts[ACT_REM_MATCH],
			action_counts[ACT_LIST]);
		$display("%0d results checked, %0d full, %0d empty, %0d misses, %0d ignored codes.",
			results_checked, full_hits, empty_hits, missing_hits, ignored_codes);
		if (errors == 0 && due_results.size() == 0) begin
			$display("tb_ordered_list_with_value_removal OK");
		end else begin
			$display("tb_ordered_list_with_value_removal NOT OK");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("tb_ordered_list_with_value_removal NOT OK");
		$finish;
	end

endmodule

FILE: ordered_list_with_value_removal.f
+incdir+sv
sv/olvr_pkg.sv
sv/olvr_ctrl.sv
sv/olvr_datapath.sv
sv/ordered_list_with_value_removal.sv
sim/tb_ordered_list_with_value_removal.sv
